FILE: rtl/cfa_pkg.sv
// Package for the chunked free-list block allocator.
// Holds pool size constants, command and status codes, and the result type.
package cfa_pkg;
	localparam int BLOCKS_PER_CHUNK = 8;
	localparam int MAX_CHUNKS = 8;
	localparam int BLOCK_W = 6;
	localparam int STATUS_W = 2;
	localparam int IN_USE_W = 7;
	localparam int CHUNK_CNT_W = 4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED = 2'd0,
		ST_FREED = 2'd1,
		ST_OUT_OF_BLOCKS = 2'd2,
		ST_INVALID_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic [BLOCK_W-1:0] granted_block;
		status_t status;
		logic [IN_USE_W-1:0] in_use_count;
		logic [CHUNK_CNT_W-1:0] chunk_count;
	} result_t;
endpackage

FILE: rtl/cfa_if.sv
// Valid/ready channel interfaces for the allocator.
// Depends on cfa_pkg for field widths.
interface cfa_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [cfa_pkg::BLOCK_W-1:0] block_id;
	modport source (output valid, cmd, block_id, input ready);
	modport sink (input valid, cmd, block_id, output ready);
endinterface

interface cfa_rsp_if;
	logic valid;
	logic ready;
	logic [cfa_pkg::BLOCK_W-1:0] granted_block;
	logic [cfa_pkg::STATUS_W-1:0] status;
	logic [cfa_pkg::IN_USE_W-1:0] in_use_count;
	logic [cfa_pkg::CHUNK_CNT_W-1:0] chunk_count;
	modport source (output valid, granted_block, status, in_use_count, chunk_count,
		input ready);
	modport sink (input valid, granted_block, status, in_use_count, chunk_count,
		output ready);
endinterface

FILE: rtl/chunked_free_list_block_allocator.sv
// Top level of the chunked free-list block allocator.
// Depends on cfa_pkg, cfa_if and cfa_link_ram.
//
// The req channel carries one command per transfer: allocate (cmd 0) or free
// of block_id (cmd 1). Each command gives exactly one transfer on rsp with
// the granted block, a status code, the blocks in use and the active chunks.
// Commands are handled one at a time by a small sequencer around two link
// memories (next and prev), each with one write and one registered read port.
// A plain allocate passes through the POP, POPW and POPF states and a plain
// free through FREE; both then stage the result and wait in OUT. Activating
// a chunk first pushes its nodes, one per ACT/RDW pair, and releasing a chunk
// unlinks its nodes, one per RELR/RELW pair reading both link memories, then
// clears it in RELF. req.ready is high only while the sequencer is idle. The
// result sits in an output register with a staging register behind it; while
// the receiver stalls, the block finishes one more command, then holds it and
// takes no new command. Reset (arst_n low) empties the list, deactivates all
// chunks and clears all counters; link memories are never read before they
// are written, so they need no clearing.
module chunked_free_list_block_allocator #(
	parameter int BLOCKS_PER_CHUNK = cfa_pkg::BLOCKS_PER_CHUNK,
	parameter int MAX_CHUNKS = cfa_pkg::MAX_CHUNKS
) (
	input logic clk,
	input logic arst_n,
	cfa_req_if.sink req,
	cfa_rsp_if.source rsp
);
	import cfa_pkg::*;

	localparam int BPC = (BLOCKS_PER_CHUNK < 3) ? 3 : BLOCKS_PER_CHUNK;
	localparam int TOTAL = BPC * MAX_CHUNKS;
	localparam int NW = $clog2(TOTAL + 1);
	localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int SW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int KW = $clog2(BPC + 1);
	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam logic [NW-1:0] NIL = NW'(TOTAL);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_ACT = 11'b00000000010,
		S_POP = 11'b00000000100,
		S_POPW = 11'b00000001000,
		S_POPF = 11'b00000010000,
		S_FREE = 11'b00000100000,
		S_RELR = 11'b00001000000,
		S_RELW = 11'b00010000000,
		S_RELF = 11'b00100000000,
		S_OUT = 11'b01000000000,
		S_RDW = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [NW-1:0] head_q;
	logic [TOTAL-1:0] taken_q;
	logic [MAX_CHUNKS-1:0] active_q;
	logic [KW-1:0] fcnt_q [MAX_CHUNKS];
	logic [NW-1:0] in_use_q;
	logic [CW-1:0] chunks_q;
	logic [SW-1:0] slot_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] node_q;
	logic [AW-1:0] blk_q;
	logic [NW-1:0] p_q, x_q;
	logic out_valid_q;
	result_t res_q;
	result_t pend_q;
	logic load_out;

	// Memory ports
	logic nwe, pwe;
	logic [AW-1:0] nwa, pwa, nra, pra;
	logic [NW-1:0] nwd, pwd, nrd, prd;

	cfa_link_ram #(.DEPTH(TOTAL), .AW(AW), .DW(NW)) u_next (
		.clk(clk), .we(nwe), .waddr(nwa), .wdata(nwd), .raddr(nra), .rdata(nrd));
	cfa_link_ram #(.DEPTH(TOTAL), .AW(AW), .DW(NW)) u_prev (
		.clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(prd));

	// Slot of a block, found by comparing against the constant slot bases.
	function automatic logic [SW-1:0] slot_of(logic [AW-1:0] b);
		logic [SW-1:0] s;
		s = '0;
		for (int i = 1; i < MAX_CHUNKS; i++) begin
			if (32'(b) >= i * BPC) s = SW'(i);
		end
		return s;
	endfunction

	// Lowest inactive slot
	logic found;
	logic [SW-1:0] free_slot;
	always_comb begin
		found = 1'b0;
		free_slot = '0;
		for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				found = 1'b1;
				free_slot = SW'(i);
			end
		end
	end

	logic [AW-1:0] slot_base;
	assign slot_base = AW'(slot_q * BPC);

	logic [SW-1:0] id_slot;
	logic id_ok;
	assign id_slot = slot_of(AW'(req.block_id));
	assign id_ok = (32'(req.block_id) < TOTAL) && active_q[id_slot]
		&& taken_q[AW'(req.block_id)];

	logic [SW-1:0] head_slot;
	assign head_slot = slot_of(head_q[AW-1:0]);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.granted_block = res_q.granted_block;
	assign rsp.status = res_q.status;
	assign rsp.in_use_count = res_q.in_use_count;
	assign rsp.chunk_count = res_q.chunk_count;

	// Memory control
	always_comb begin
		nwe = 1'b0; pwe = 1'b0;
		nwa = '0; pwa = '0; nwd = '0; pwd = '0;
		nra = head_q[AW-1:0]; pra = head_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.cmd == CMD_FREE && id_ok) begin
					// Push at head.
					nwe = 1'b1; nwa = AW'(req.block_id); nwd = head_q;
					pwe = 1'b1; pwa = AW'(req.block_id); pwd = NIL;
				end
			end
			S_FREE: begin
				if (p_q != NIL) begin
					pwe = 1'b1; pwa = p_q[AW-1:0]; pwd = NW'(blk_q);
				end
			end
			S_ACT: begin
				nwe = 1'b1; nwa = slot_base + AW'(k_q - 1'b1); nwd = head_q;
				pwe = 1'b1; pwa = slot_base + AW'(k_q - 1'b1); pwd = NIL;
			end
			S_RDW: begin
				// The node pushed last cycle becomes prev of the old head.
				if (x_q != NIL) begin
					pwe = 1'b1; pwa = x_q[AW-1:0]; pwd = head_q;
				end
			end
			S_POP: begin
				nra = head_q[AW-1:0];
			end
			S_POPW: begin
				if (nrd != NIL) begin
					pwe = 1'b1; pwa = nrd[AW-1:0]; pwd = NIL;
				end
			end
			S_RELR: begin
				nra = node_q; pra = node_q;
			end
			S_RELW: begin
				if (nrd != NIL) begin
					pwe = 1'b1; pwa = nrd[AW-1:0]; pwd = prd;
				end
				if (prd != NIL) begin
					nwe = 1'b1; nwa = prd[AW-1:0]; nwd = nrd;
				end
			end
			default: ;
		endcase
	end

	assign load_out = (state_q == S_OUT) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL;
			taken_q <= '0;
			active_q <= '0;
			for (int i = 0; i < MAX_CHUNKS; i++) fcnt_q[i] <= '0;
			in_use_q <= '0;
			chunks_q <= '0;
			slot_q <= '0;
			k_q <= '0;
			node_q <= '0;
			blk_q <= '0;
			p_q <= NIL;
			x_q <= NIL;
			pend_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						blk_q <= AW'(req.block_id);
						if (req.cmd == CMD_ALLOC) begin
							if (head_q != NIL) begin
								state_q <= S_POP;
							end else if (found) begin
								slot_q <= free_slot;
								k_q <= KW'(BPC);
								state_q <= S_ACT;
							end else begin
								pend_q <= '{'0, ST_OUT_OF_BLOCKS, IN_USE_W'(in_use_q),
									CHUNK_CNT_W'(chunks_q)};
								state_q <= S_OUT;
							end
						end else if (!id_ok) begin
							pend_q <= '{'0, ST_INVALID_FREE, IN_USE_W'(in_use_q),
								CHUNK_CNT_W'(chunks_q)};
							state_q <= S_OUT;
						end else begin
							taken_q[AW'(req.block_id)] <= 1'b0;
							in_use_q <= in_use_q - 1'b1;
							fcnt_q[id_slot] <= fcnt_q[id_slot] + 1'b1;
							slot_q <= id_slot;
							p_q <= head_q;
							head_q <= NW'(req.block_id);
							state_q <= S_FREE;
						end
					end
				end
				S_FREE: begin
					// Prev of the old head is fixed this cycle.
					if (32'(fcnt_q[slot_q]) == BPC && chunks_q > CW'(1)) begin
						k_q <= '0;
						node_q <= slot_base;
						state_q <= S_RELR;
					end else begin
						pend_q <= '{'0, ST_FREED, IN_USE_W'(in_use_q),
							CHUNK_CNT_W'(chunks_q)};
						state_q <= S_OUT;
					end
				end
				S_ACT: begin
					x_q <= head_q;
					head_q <= NW'(slot_base + AW'(k_q - 1'b1));
					state_q <= S_RDW;
				end
				S_RDW: begin
					if (k_q == KW'(1)) begin
						active_q[slot_q] <= 1'b1;
						fcnt_q[slot_q] <= KW'(BPC);
						chunks_q <= chunks_q + 1'b1;
						state_q <= S_POP;
					end else begin
						k_q <= k_q - 1'b1;
						state_q <= S_ACT;
					end
				end
				S_POP: state_q <= S_POPW;
				S_POPW: begin
					head_q <= nrd;
					taken_q[head_q[AW-1:0]] <= 1'b1;
					fcnt_q[head_slot] <= fcnt_q[head_slot] - 1'b1;
					in_use_q <= in_use_q + 1'b1;
					blk_q <= head_q[AW-1:0];
					state_q <= S_POPF;
				end
				S_POPF: begin
					pend_q <= '{BLOCK_W'(blk_q), ST_GRANTED, IN_USE_W'(in_use_q),
						CHUNK_CNT_W'(chunks_q)};
					state_q <= S_OUT;
				end
				S_RELR: state_q <= S_RELW;
				S_RELW: begin
					if (prd == NIL) head_q <= nrd;
					if (32'(k_q) == BPC - 1) begin
						state_q <= S_RELF;
					end else begin
						k_q <= k_q + 1'b1;
						node_q <= node_q + 1'b1;
						state_q <= S_RELR;
					end
				end
				S_RELF: begin
					active_q[slot_q] <= 1'b0;
					fcnt_q[slot_q] <= '0;
					chunks_q <= chunks_q - 1'b1;
					pend_q <= '{'0, ST_FREED, IN_USE_W'(in_use_q),
						CHUNK_CNT_W'(chunks_q - 1'b1)};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (load_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: loaded from the staging register once it is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			res_q <= '0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
			res_q <= pend_q;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !(state_q != S_IDLE))
		else $error("ready outside idle");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		32'(chunks_q) <= MAX_CHUNKS)
		else $error("chunk count overflow");
	a_inuse: assert property (@(posedge clk) disable iff (!arst_n)
		32'(in_use_q) <= TOTAL)
		else $error("in-use count overflow");
endmodule

FILE: rtl/cfa_link_ram.sv
// One link array (next or prev) of the free list: one write and one read port.
// Read data is registered. Depends on nothing but its parameters.
module cfa_link_ram #(
	parameter int DEPTH = 64,
	parameter int AW = 6,
	parameter int DW = 7
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [DW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: tb/sv/cfa_tb_channels.sv
`timescale 1ns / 1ps
// Testbench constants for the allocator: pool size and the null link value.
// Depends on cfa_pkg for the pool size constants; the RTL interfaces are used for the block itself.
package cfa_tb_codes;
	import cfa_pkg::*;
	localparam int POOL_BLOCKS = BLOCKS_PER_CHUNK * MAX_CHUNKS;
	localparam int LINK_NULL = POOL_BLOCKS;
endpackage

FILE: tb/sv/cfa_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the chunked free-list block allocator.
// Depends on cfa_pkg, cfa_tb_codes and the cfa_req_if / cfa_rsp_if interfaces.
module cfa_checker (
	input logic clk,
	input logic arst_n,
	cfa_req_if req,
	cfa_rsp_if rsp,
	output int errors,
	output int pending
);
	import cfa_pkg::*;
	import cfa_tb_codes::*;

	int free_head;
	int next_link[POOL_BLOCKS];
	int prev_link[POOL_BLOCKS];
	bit block_taken[POOL_BLOCKS];
	bit slot_active[MAX_CHUNKS];
	int slot_free_count[MAX_CHUNKS];
	int blocks_in_use;
	int active_chunks;
	result_t expected_results[$];

	assign pending = expected_results.size();

	function automatic void unlink(int n);
		int p;
		int x;
		p = prev_link[n];
		x = next_link[n];
		if (x != LINK_NULL)
			prev_link[x] = p;
		if (p == LINK_NULL)
			free_head = x;
		else
			next_link[p] = x;
	endfunction

	function automatic void push_head(int n);
		next_link[n] = free_head;
		prev_link[n] = LINK_NULL;
		if (free_head != LINK_NULL)
			prev_link[free_head] = n;
		free_head = n;
	endfunction

	function automatic result_t predict_result(logic cmd, logic [BLOCK_W-1:0] id);
		result_t r;
		int s;
		int n;
		r = '0;
		if (cmd == CMD_ALLOC) begin
			if (free_head == LINK_NULL) begin
				for (s = 0; s < MAX_CHUNKS; s++)
					if (!slot_active[s])
						break;
				if (s < MAX_CHUNKS) begin
					// Index 0 of the new chunk must end up at the head.
					for (int k = BLOCKS_PER_CHUNK - 1; k >= 0; k--)
						push_head(s * BLOCKS_PER_CHUNK + k);
					slot_active[s] = 1;
					slot_free_count[s] = BLOCKS_PER_CHUNK;
					active_chunks++;
				end
			end
			if (free_head == LINK_NULL) begin
				r.status = ST_OUT_OF_BLOCKS;
			end else begin
				n = free_head;
				unlink(n);
				block_taken[n] = 1;
				slot_free_count[n / BLOCKS_PER_CHUNK]--;
				blocks_in_use++;
				r.granted_block = BLOCK_W'(n);
				r.status = ST_GRANTED;
			end
		end else begin
			s = id / BLOCKS_PER_CHUNK;
			if (id >= POOL_BLOCKS || !slot_active[s] || !block_taken[id]) begin
				r.status = ST_INVALID_FREE;
			end else begin
				block_taken[id] = 0;
				blocks_in_use--;
				push_head(id);
				slot_free_count[s]++;
				if (slot_free_count[s] == BLOCKS_PER_CHUNK && active_chunks > 1) begin
					for (int k = 0; k < BLOCKS_PER_CHUNK; k++)
						unlink(s * BLOCKS_PER_CHUNK + k);
					slot_active[s] = 0;
					slot_free_count[s] = 0;
					active_chunks--;
				end
				r.status = ST_FREED;
			end
		end
		r.in_use_count = IN_USE_W'(blocks_in_use);
		r.chunk_count = CHUNK_CNT_W'(active_chunks);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			free_head = LINK_NULL;
			for (int i = 0; i < POOL_BLOCKS; i++) begin
				next_link[i] = 0;
				prev_link[i] = 0;
				block_taken[i] = 0;
			end
			for (int i = 0; i < MAX_CHUNKS; i++) begin
				slot_active[i] = 0;
				slot_free_count[i] = 0;
			end
			blocks_in_use = 0;
			active_chunks = 0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.granted_block = rsp.granted_block;
				got.status = status_t'(rsp.status);
				got.in_use_count = rsp.in_use_count;
				got.chunk_count = rsp.chunk_count;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.granted_block !== want.granted_block) begin
						$error("granted_block expected %0d got %0d",
							want.granted_block, got.granted_block);
						errors++;
					end
					if (got.status !== want.status) begin
						$error("status expected %0d got %0d", want.status, got.status);
						errors++;
					end
					if (got.in_use_count !== want.in_use_count) begin
						$error("in_use_count expected %0d got %0d",
							want.in_use_count, got.in_use_count);
						errors++;
					end
					if (got.chunk_count !== want.chunk_count) begin
						$error("chunk_count expected %0d got %0d",
							want.chunk_count, got.chunk_count);
						errors++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(predict_result(req.cmd, req.block_id));
		end
	end
endmodule

FILE: tb/sv/tb_chunked_free_list_block_allocator.sv
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command stimulus and verdict.
// Depends on cfa_pkg, cfa_tb_codes, the channel interfaces and cfa_checker.
module tb_chunked_free_list_block_allocator;
	import cfa_pkg::*;
	import cfa_tb_codes::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int cycles;
	bit hold_rsp;
	bit stimulus_done;
	logic [BLOCK_W-1:0] held_blocks[$];

	cfa_req_if req ();
	cfa_rsp_if rsp ();

	chunked_free_list_block_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	cfa_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int gap_length();
		if ($urandom_range(0, 3) == 0)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Drives one command and waits for its transfer on req. The held-block view that
	// lets most frees name a really allocated block is kept by free_held and the response side.
	task automatic send(logic cmd, logic [BLOCK_W-1:0] id, bit gaps);
		int g;
		g = gaps ? gap_length() : 0;
		if (g > 0) begin
			req.valid <= 0;
			repeat (g) @(negedge clk);
		end
		req.valid <= 1;
		req.cmd <= cmd;
		req.block_id <= id;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// Keeps the held-block list approximately right from the response side.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (rsp.status == ST_GRANTED)
				held_blocks.push_back(rsp.granted_block);
		end
	end

	task automatic free_held(bit gaps);
		int i;
		logic [BLOCK_W-1:0] b;
		if (held_blocks.size() == 0) begin
			send(CMD_FREE, BLOCK_W'($urandom_range(0, POOL_BLOCKS - 1)), gaps);
		end else begin
			i = $urandom_range(0, held_blocks.size() - 1);
			b = held_blocks[i];
			held_blocks.delete(i);
			send(CMD_FREE, b, gaps);
		end
	endtask

	// Receiver: random stalls, with a long hold-off when hold_rsp is set.
	initial begin
		int g;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp.ready <= 0;
				repeat (200) @(negedge clk);
				hold_rsp = 0;
			end
			if (stimulus_done || $urandom_range(0, 2) != 0) begin
				rsp.ready <= 1;
			end else begin
				g = gap_length();
				if (g > 0) begin
					rsp.ready <= 0;
					repeat (g) @(negedge clk);
				end
				rsp.ready <= 1;
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		hold_rsp = 0;
		stimulus_done = 0;
		arst_n = 0;
		req.valid = 0;
		req.cmd = CMD_ALLOC;
		req.block_id = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: bad frees on an empty pool, fill all chunks, overflow,
		// double and out-of-range style frees, release down to one chunk.
		send(CMD_FREE, 6'd0, 1'b0);
		send(CMD_FREE, 6'h3f, 1'b0);
		send(CMD_ALLOC, 6'h3f, 1'b0);
		send(CMD_FREE, 6'd0, 1'b0);
		send(CMD_FREE, 6'd0, 1'b0);
		send(CMD_ALLOC, 6'd0, 1'b0);
		send(CMD_FREE, 6'd9, 1'b0);
		wait_drained();
		held_blocks.delete();
		held_blocks.push_back(6'd0);
		repeat (POOL_BLOCKS - 1)
			send(CMD_ALLOC, BLOCK_W'($urandom), 1'b1);
		send(CMD_ALLOC, 6'd0, 1'b0);
		send(CMD_ALLOC, 6'h2a, 1'b0);
		wait_drained();
		while (held_blocks.size() > 0)
			free_held(1'b1);
		send(CMD_FREE, 6'h3f, 1'b0);
		send(CMD_FREE, 6'h15, 1'b0);
		wait_drained();

		// Long receiver hold-off while commands keep coming.
		hold_rsp = 1;
		repeat (6)
			send(CMD_ALLOC, 6'd0, 1'b0);
		wait_drained();

		// Random: alternate fill-heavy and drain-heavy stretches.
		for (int n = 0; n < 2000; n++) begin
			mode = (n / 150) % 2;
			if ($urandom_range(0, 19) == 0)
				send(CMD_FREE, BLOCK_W'($urandom), 1'b1);
			else if ($urandom_range(0, 9) < (mode ? 3 : 7))
				send(CMD_ALLOC, BLOCK_W'($urandom), 1'b1);
			else
				free_held(1'b1);
			if (n == 1000)
				wait_drained();
		end

		stimulus_done = 1;
		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/cfa_pkg.sv
rtl/cfa_if.sv
rtl/cfa_link_ram.sv
rtl/chunked_free_list_block_allocator.sv
tb/sv/cfa_tb_channels.sv
tb/sv/cfa_checker.sv
tb/sv/tb_chunked_free_list_block_allocator.sv
